// File: rtl/ps2s1_pkg.sv
// ============================================================================
// ps2s1_pkg
// Shared types and constants for the PS/2 set 1 decoder with typematic repeat.
// ============================================================================
`default_nettype none

package ps2s1_pkg;

    localparam int CODE_W  = 7;
    localparam int BYTE_W  = 8;
    localparam int TIME_W  = 32;
    localparam int MOD_W   = 5;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    // Command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 1'b1;

    localparam logic [CFG_W-1:0] REPEAT_DELAY_RST  = 16'd500;
    localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = 16'd30;

    // Set 1 scancodes
    localparam logic [BYTE_W-1:0] SC_PREFIX = 8'hE0;
    localparam int                SC_BREAK_BIT = 7;
    localparam logic [CODE_W-1:0] SC_LSHIFT = 7'h2A;
    localparam logic [CODE_W-1:0] SC_RSHIFT = 7'h36;
    localparam logic [CODE_W-1:0] SC_CTRL   = 7'h1D;
    localparam logic [CODE_W-1:0] SC_ALT    = 7'h38;
    localparam logic [CODE_W-1:0] SC_CAPS   = 7'h3A;

    // Modifier mask bits
    localparam int MOD_SHIFT_BIT = 0;
    localparam int MOD_CTRL_BIT  = 1;
    localparam int MOD_ALT_BIT   = 2;
    localparam int MOD_ALTGR_BIT = 3;
    localparam int MOD_CAPS_BIT  = 4;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_SHIFT = 3'd1,
        OP_CTRL  = 3'd2,
        OP_ALT   = 3'd3,
        OP_ALTGR = 3'd4,
        OP_CAPS  = 3'd5
    } mod_op_t;

    typedef struct packed {
        logic               tick;
        logic               make;
        logic               ext;
        logic [CODE_W-1:0]  code;
        mod_op_t            mod_op;
        logic [TIME_W-1:0]  now_ms;
    } q_entry_t;

endpackage

`default_nettype wire

// File: rtl/ps2s1_ifs.sv
// ============================================================================
// ps2s1 channel interfaces
// Valid/ready channels for input items, result items and config writes.
// ============================================================================
`default_nettype none

interface ps2s1_item_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [ps2s1_pkg::BYTE_W-1:0]   scan_byte;
    logic [ps2s1_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, command, scan_byte, now_ms, input ready);
    modport sink   (input valid, command, scan_byte, now_ms, output ready);
endinterface

interface ps2s1_result_if;
    logic                           valid;
    logic                           ready;
    logic [ps2s1_pkg::CODE_W-1:0]   key_code;
    logic                           extended;
    logic                           pressed;
    logic                           repeated;
    logic [ps2s1_pkg::MOD_W-1:0]    modifiers;

    modport source (output valid, key_code, extended, pressed, repeated, modifiers,
                    input ready);
    modport sink   (input valid, key_code, extended, pressed, repeated, modifiers,
                    output ready);
endinterface

interface ps2s1_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ps2s1_pkg::CFG_IDX_W-1:0]  index;
    logic [ps2s1_pkg::CFG_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/ps2_set1_scancode_typematic.sv
// Result path: an accepted input goes into a queue entry, then into the output register,
// which drives result valid.
// Throughput: one input beat per cycle; the front stalls only when the 2-entry queue is full,
// which happens only while the result channel is held off.
// Prefix bytes and ticks with no repeat due produce no result.
// Reset: modifiers, prefix and repeat state cleared; delay 500 ms, period 30 ms.
// ============================================================================
// ps2_set1_scancode_typematic
// PS/2 set 1 scancode decoder with typematic repeat, front/queue/back split.
// ============================================================================
`default_nettype none

module ps2_set1_scancode_typematic (
    input  wire logic       clk,
    input  wire logic       rst_n,
    ps2s1_item_if.sink      item,
    ps2s1_result_if.source  result,
    ps2s1_cfg_if.sink       cfg
);

    logic                               q_full;
    logic                               push;
    ps2s1_pkg::q_entry_t                push_entry;
    logic                               pop;
    logic                               q_valid;
    ps2s1_pkg::q_entry_t                q_entry;
    logic [ps2s1_pkg::CFG_W-1:0]        repeat_delay;
    logic [ps2s1_pkg::CFG_W-1:0]        repeat_period;

    ps2s1_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .repeat_delay  (repeat_delay),
        .repeat_period (repeat_period)
    );

    ps2s1_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    ps2s1_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    ps2s1_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .pop           (pop),
        .repeat_delay  (repeat_delay),
        .repeat_period (repeat_period),
        .result        (result)
    );

    // a prefix byte never becomes a queue entry
    a_prefix_absorbed: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.command == ps2s1_pkg::CMD_BYTE &&
         item.scan_byte == ps2s1_pkg::SC_PREFIX) |-> !push)
        else $error("prefix byte pushed into queue");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("push into full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

    // repeat events are always presses
    a_repeat_is_press: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.repeated) |-> result.pressed)
        else $error("repeat event without press");

    a_cfg_delay_written: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready && cfg.index == ps2s1_pkg::CFG_REPEAT_DELAY)
        |=> repeat_delay == $past(cfg.data))
        else $error("repeat delay not updated");

endmodule

`default_nettype wire

// File: rtl/ps2s1_front.sv
// ============================================================================
// ps2s1_front
// Accepts input beats, folds the 0xE0 prefix in and classifies each byte.
// ============================================================================
`default_nettype none

module ps2s1_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    ps2s1_item_if.sink              item,
    input  wire logic               q_full,
    output logic                    push,
    output ps2s1_pkg::q_entry_t     push_entry
);

    logic prefix_reg;
    logic prefix_next;
    logic is_prefix;
    logic accept;

    assign item.ready = !q_full;
    assign accept     = item.valid && item.ready;
    assign is_prefix  = (item.command == ps2s1_pkg::CMD_BYTE) &&
                        (item.scan_byte == ps2s1_pkg::SC_PREFIX);
    // prefix bytes are absorbed here and never reach the queue
    assign push       = accept && !is_prefix;

    always_comb
    begin
        push_entry.tick   = (item.command == ps2s1_pkg::CMD_TICK);
        push_entry.make   = !item.scan_byte[ps2s1_pkg::SC_BREAK_BIT];
        push_entry.ext    = prefix_reg;
        push_entry.code   = item.scan_byte[ps2s1_pkg::CODE_W-1:0];
        push_entry.now_ms = item.now_ms;
        push_entry.mod_op = ps2s1_pkg::OP_NONE;
        if (push_entry.code == ps2s1_pkg::SC_LSHIFT ||
            push_entry.code == ps2s1_pkg::SC_RSHIFT)
        begin
            push_entry.mod_op = ps2s1_pkg::OP_SHIFT;
        end
        else if (push_entry.code == ps2s1_pkg::SC_CTRL)
        begin
            push_entry.mod_op = ps2s1_pkg::OP_CTRL;
        end
        else if (push_entry.code == ps2s1_pkg::SC_ALT)
        begin
            push_entry.mod_op = prefix_reg ? ps2s1_pkg::OP_ALTGR : ps2s1_pkg::OP_ALT;
        end
        else if (push_entry.code == ps2s1_pkg::SC_CAPS && push_entry.make)
        begin
            push_entry.mod_op = ps2s1_pkg::OP_CAPS;
        end
    end

    always_comb
    begin
        prefix_next = prefix_reg;
        // ticks leave the prefix alone
        if (accept && item.command == ps2s1_pkg::CMD_BYTE)
        begin
            prefix_next = is_prefix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= 1'b0;
        end
        else
        begin
            prefix_reg <= prefix_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ps2s1_queue.sv
// ============================================================================
// ps2s1_queue
// Two-entry queue of classified items between the front and the back.
// ============================================================================
`default_nettype none

module ps2s1_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire ps2s1_pkg::q_entry_t   push_entry,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       q_valid,
    output ps2s1_pkg::q_entry_t        q_entry
);

    ps2s1_pkg::q_entry_t                    entry_reg [ps2s1_pkg::QUEUE_DEPTH];
    logic [ps2s1_pkg::QUEUE_PTR_W-1:0]      wr_ptr_reg;
    logic [ps2s1_pkg::QUEUE_PTR_W-1:0]      wr_ptr_next;
    logic [ps2s1_pkg::QUEUE_PTR_W-1:0]      rd_ptr_reg;
    logic [ps2s1_pkg::QUEUE_PTR_W-1:0]      rd_ptr_next;
    logic [ps2s1_pkg::QUEUE_CNT_W-1:0]      count_reg;
    logic [ps2s1_pkg::QUEUE_CNT_W-1:0]      count_next;

    assign full    = (count_reg == ps2s1_pkg::QUEUE_CNT_W'(ps2s1_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ps2s1_back.sv
// ============================================================================
// ps2s1_back
// Modifier and typematic state; turns queued items into key events.
// ============================================================================
`default_nettype none

module ps2s1_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_valid,
    input  wire ps2s1_pkg::q_entry_t            q_entry,
    output logic                                pop,
    input  wire logic [ps2s1_pkg::CFG_W-1:0]    repeat_delay,
    input  wire logic [ps2s1_pkg::CFG_W-1:0]    repeat_period,
    ps2s1_result_if.source                      result
);

    logic [ps2s1_pkg::MOD_W-1:0]    mask_reg,        mask_next;
    logic                           armed_reg,       armed_next;
    logic [ps2s1_pkg::CODE_W:0]     key_reg,         key_next;
    logic [ps2s1_pkg::TIME_W-1:0]   press_reg,       press_next;
    logic [ps2s1_pkg::TIME_W-1:0]   last_reg,        last_next;
    logic                           first_done_reg,  first_done_next;

    logic                           out_valid_reg,   out_valid_next;
    logic [ps2s1_pkg::CODE_W-1:0]   out_code_reg,    out_code_next;
    logic                           out_ext_reg,     out_ext_next;
    logic                           out_pressed_reg, out_pressed_next;
    logic                           out_rep_reg,     out_rep_next;
    logic [ps2s1_pkg::MOD_W-1:0]    out_mods_reg,    out_mods_next;

    logic [ps2s1_pkg::TIME_W-1:0]   since_press;
    logic [ps2s1_pkg::TIME_W-1:0]   since_last;
    logic                           emit;

    // output slot free or being drained this cycle
    assign pop = q_valid && (!out_valid_reg || result.ready);

    assign since_press = q_entry.now_ms - press_reg;
    assign since_last  = q_entry.now_ms - last_reg;

    always_comb
    begin
        mask_next        = mask_reg;
        armed_next       = armed_reg;
        key_next         = key_reg;
        press_next       = press_reg;
        last_next        = last_reg;
        first_done_next  = first_done_reg;
        emit             = 1'b0;
        out_code_next    = out_code_reg;
        out_ext_next     = out_ext_reg;
        out_pressed_next = out_pressed_reg;
        out_rep_next     = out_rep_reg;

        if (pop)
        begin
            if (!q_entry.tick)
            begin
                case (q_entry.mod_op)
                    ps2s1_pkg::OP_SHIFT: mask_next[ps2s1_pkg::MOD_SHIFT_BIT] = q_entry.make;
                    ps2s1_pkg::OP_CTRL:  mask_next[ps2s1_pkg::MOD_CTRL_BIT]  = q_entry.make;
                    ps2s1_pkg::OP_ALT:   mask_next[ps2s1_pkg::MOD_ALT_BIT]   = q_entry.make;
                    ps2s1_pkg::OP_ALTGR: mask_next[ps2s1_pkg::MOD_ALTGR_BIT] = q_entry.make;
                    ps2s1_pkg::OP_CAPS:
                        mask_next[ps2s1_pkg::MOD_CAPS_BIT] =
                            !mask_reg[ps2s1_pkg::MOD_CAPS_BIT];
                    default: ;
                endcase

                if (q_entry.make)
                begin
                    armed_next      = 1'b1;
                    key_next        = {q_entry.ext, q_entry.code};
                    press_next      = q_entry.now_ms;
                    last_next       = '0;
                    first_done_next = 1'b0;
                end
                else if (armed_reg && key_reg == {q_entry.ext, q_entry.code})
                begin
                    armed_next = 1'b0;
                end

                emit             = 1'b1;
                out_code_next    = q_entry.code;
                out_ext_next     = q_entry.ext;
                out_pressed_next = q_entry.make;
                out_rep_next     = 1'b0;
            end
            else if (armed_reg &&
                     since_press >= {{(ps2s1_pkg::TIME_W-ps2s1_pkg::CFG_W){1'b0}},
                                     repeat_delay} &&
                     (!first_done_reg ||
                      since_last >= {{(ps2s1_pkg::TIME_W-ps2s1_pkg::CFG_W){1'b0}},
                                     repeat_period}))
            begin
                first_done_next  = 1'b1;
                last_next        = q_entry.now_ms;
                emit             = 1'b1;
                out_code_next    = key_reg[ps2s1_pkg::CODE_W-1:0];
                out_ext_next     = key_reg[ps2s1_pkg::CODE_W];
                out_pressed_next = 1'b1;
                out_rep_next     = 1'b1;
            end
        end

        out_mods_next = emit ? mask_next : out_mods_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg       <= '0;
            armed_reg      <= 1'b0;
            key_reg        <= '0;
            press_reg      <= '0;
            last_reg       <= '0;
            first_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mask_reg       <= mask_next;
            armed_reg      <= armed_next;
            key_reg        <= key_next;
            press_reg      <= press_next;
            last_reg       <= last_next;
            first_done_reg <= first_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg    <= out_code_next;
        out_ext_reg     <= out_ext_next;
        out_pressed_reg <= out_pressed_next;
        out_rep_reg     <= out_rep_next;
        out_mods_reg    <= out_mods_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.key_code  = out_code_reg;
    assign result.extended  = out_ext_reg;
    assign result.pressed   = out_pressed_reg;
    assign result.repeated  = out_rep_reg;
    assign result.modifiers = out_mods_reg;

endmodule

`default_nettype wire

// File: rtl/ps2s1_set1_scancode_typematic_dummy_guard.sv
// ============================================================================
// ps2s1_cfg
// Configuration registers for repeat delay and repeat period.
// ============================================================================
`default_nettype none

module ps2s1_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ps2s1_cfg_if.sink                           cfg,
    output logic [ps2s1_pkg::CFG_W-1:0]         repeat_delay,
    output logic [ps2s1_pkg::CFG_W-1:0]         repeat_period
);

    logic [ps2s1_pkg::CFG_W-1:0] delay_reg,  delay_next;
    logic [ps2s1_pkg::CFG_W-1:0] period_reg, period_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        delay_next  = delay_reg;
        period_next = period_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                ps2s1_pkg::CFG_REPEAT_DELAY:  delay_next  = cfg.data;
                ps2s1_pkg::CFG_REPEAT_PERIOD: period_next = cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg  <= ps2s1_pkg::REPEAT_DELAY_RST;
            period_reg <= ps2s1_pkg::REPEAT_PERIOD_RST;
        end
        else
        begin
            delay_reg  <= delay_next;
            period_reg <= period_next;
        end
    end

    assign repeat_delay  = delay_reg;
    assign repeat_period = period_reg;

endmodule

`default_nettype wire
